FILE: rtl/core/lrp_pkg.sv
// ----------------------------------------------------------------------------
// lrp_pkg
// Shared widths, codes and parameter defaults for the LR parse engine.
// ----------------------------------------------------------------------------
package lrp_pkg;

    // Field widths of the input and result beats
    localparam int CMD_W    = 2;
    localparam int STATE_W  = 8;
    localparam int SYM_W    = 6;
    localparam int KIND_W   = 2;
    localparam int TARGET_W = 8;
    localparam int RULE_W   = 7;
    localparam int LEN_W    = 4;
    localparam int HEAD_W   = 6;
    localparam int TOKEN_W  = 6;
    localparam int RES_W    = 3;
    localparam int VAL_W    = 8;

    // Stored word widths: {kind, target} and {length, head}
    localparam int ENTRY_W  = KIND_W + TARGET_W;
    localparam int RENTRY_W = LEN_W + HEAD_W;

    // Parameter defaults
    localparam int DEF_NUM_STATES  = 256;
    localparam int DEF_NUM_SYMBOLS = 64;
    localparam int DEF_NUM_RULES   = 128;
    localparam int DEF_STACK_DEPTH = 64;
    localparam int DEF_MAX_REDUCES = 63;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_ENTRY = 2'd0,
        CMD_LOAD_RULE  = 2'd1,
        CMD_START      = 2'd2,
        CMD_TOKEN      = 2'd3
    } t_cmd;

    typedef enum logic [KIND_W-1:0] {
        KIND_ERROR  = 2'd0,
        KIND_SHIFT  = 2'd1,
        KIND_REDUCE = 2'd2,
        KIND_ACCEPT = 2'd3
    } t_kind;

    typedef enum logic [RES_W-1:0] {
        EV_SHIFT  = 3'd0,
        EV_REDUCE = 3'd1,
        EV_ACCEPT = 3'd2,
        EV_ERROR  = 3'd3,
        EV_ACK    = 3'd4
    } t_event;

endpackage

FILE: rtl/core/lrp_if.sv
// ----------------------------------------------------------------------------
// lrp_if
// Valid/ready channels of the LR parse engine: command beats in, events out.
// ----------------------------------------------------------------------------
interface lrp_in_if import lrp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [STATE_W-1:0]  table_state;
    logic [SYM_W-1:0]    table_symbol;
    logic [KIND_W-1:0]   entry_kind;
    logic [TARGET_W-1:0] entry_target;
    logic [RULE_W-1:0]   rule_number;
    logic [LEN_W-1:0]    rule_length;
    logic [HEAD_W-1:0]   rule_head;
    logic [TOKEN_W-1:0]  token_type;

    modport source (
        output valid, command, table_state, table_symbol, entry_kind,
               entry_target, rule_number, rule_length, rule_head, token_type,
        input  ready
    );
    modport sink (
        input  valid, command, table_state, table_symbol, entry_kind,
               entry_target, rule_number, rule_length, rule_head, token_type,
        output ready
    );
endinterface

interface lrp_out_if import lrp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [RES_W-1:0] event_res;
    logic [VAL_W-1:0] event_value;
    logic             last;

    modport source (output valid, event_res, event_value, last, input ready);
    modport sink   (input  valid, event_res, event_value, last, output ready);
endinterface

FILE: rtl/core/lr_shift_reduce_parse_engine.sv
// ----------------------------------------------------------------------------
// lr_shift_reduce_parse_engine
// Table-driven LR parse engine: table/rule loading, parse start, and the
// shift/reduce driver over an action/goto memory, a rule memory and a stack.
// ----------------------------------------------------------------------------
//  channel  | dir | beat                                   | accepted when
//  ---------+-----+----------------------------------------+-----------------
//  i_in     | in  | command, load fields, token_type       | valid & ready
//  o_out    | out | event_res, event_value, last           | valid & ready
//
//  Load and start beats pass through S_ACK. A token runs S_ACT, S_DEC and,
//  per reduction, S_RULE, S_POP (not for an empty rule) and S_GTD, then
//  S_ERR if it ends in an error; a token with no active parse goes straight
//  to S_ERR. Each action/goto lookup, rule read and pop read is a registered
//  memory read. Reset empties the stack and leaves no parse active; memories
//  are not cleared. A full output register stalls each step that emits.
// ----------------------------------------------------------------------------
module lr_shift_reduce_parse_engine import lrp_pkg::*; #(
    parameter int NUM_STATES  = DEF_NUM_STATES,
    parameter int NUM_SYMBOLS = DEF_NUM_SYMBOLS,
    parameter int NUM_RULES   = DEF_NUM_RULES,
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int MAX_REDUCES = DEF_MAX_REDUCES
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lrp_in_if.sink       i_in,
    lrp_out_if.source    o_out
);

    localparam int AT_DEPTH = NUM_STATES * NUM_SYMBOLS;
    localparam int AW       = $clog2(AT_DEPTH);
    localparam int RUW      = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
    localparam int SIW      = $clog2(STACK_DEPTH);
    localparam int SPW      = $clog2(STACK_DEPTH + 1);
    localparam int RW       = $clog2(MAX_REDUCES + 1);

    localparam logic [AW-1:0]  SYMS_A   = AW'(NUM_SYMBOLS);
    localparam logic [SPW-1:0] DEPTH_SP = SPW'(STACK_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACK,
        S_ACT,
        S_DEC,
        S_RULE,
        S_POP,
        S_GTD,
        S_ERR
    } t_state;

    function automatic logic [AW-1:0] f_at_addr(input logic [STATE_W-1:0] st,
                                                 input logic [SYM_W-1:0]   sym);
        return AW'(AW'(st) * SYMS_A) + AW'(sym);
    endfunction

    // Registers
    t_state              r_state, n_state;
    logic [SPW-1:0]      r_sp, n_sp;
    logic                r_finished, n_finished;
    logic [STATE_W-1:0]  r_top, n_top;
    logic [TOKEN_W-1:0]  r_tok, n_tok;
    logic [HEAD_W-1:0]   r_head, n_head;
    logic [TARGET_W-1:0] r_rule, n_rule;
    logic [RW-1:0]       r_reduces, n_reduces;
    logic                r_out_valid, n_out_valid;
    t_event              r_out_res, n_out_res;
    logic [VAL_W-1:0]    r_out_value, n_out_value;
    logic                r_out_last, n_out_last;

    // Memories and their ports
    logic [ENTRY_W-1:0]  r_action_mem [AT_DEPTH];
    logic [RENTRY_W-1:0] r_rule_mem   [NUM_RULES];
    logic [STATE_W-1:0]  r_stack_mem  [STACK_DEPTH];

    logic                at_we, at_re;
    logic [AW-1:0]       at_waddr, at_raddr;
    logic [ENTRY_W-1:0]  at_wdata, r_at_rdata;
    logic                rt_we, rt_re;
    logic [RUW-1:0]      rt_waddr, rt_raddr;
    logic [RENTRY_W-1:0] rt_wdata, r_rt_rdata;
    logic                st_we, st_re;
    logic [SIW-1:0]      st_waddr, st_raddr;
    logic [STATE_W-1:0]  st_wdata, r_st_rdata;

    logic                slot_free;
    t_kind               dec_kind;
    logic [TARGET_W-1:0] dec_target;
    logic [LEN_W-1:0]    rule_len;
    logic [HEAD_W-1:0]   rule_hd;
    logic [SPW-1:0]      sp_popped;

    assign slot_free  = !r_out_valid || o_out.ready;
    assign dec_kind   = t_kind'(r_at_rdata[ENTRY_W-1:TARGET_W]);
    assign dec_target = r_at_rdata[TARGET_W-1:0];
    assign rule_len   = r_rt_rdata[RENTRY_W-1:HEAD_W];
    assign rule_hd    = r_rt_rdata[HEAD_W-1:0];
    assign sp_popped  = r_sp - SPW'(rule_len);

    always_comb begin
        n_state     = r_state;
        n_sp        = r_sp;
        n_finished  = r_finished;
        n_top       = r_top;
        n_tok       = r_tok;
        n_head      = r_head;
        n_rule      = r_rule;
        n_reduces   = r_reduces;
        n_out_valid = r_out_valid;
        n_out_res   = r_out_res;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;

        at_we    = 1'b0;
        at_waddr = f_at_addr(i_in.table_state, i_in.table_symbol);
        at_wdata = {i_in.entry_kind, i_in.entry_target};
        at_re    = 1'b0;
        at_raddr = f_at_addr(r_top, r_tok);
        rt_we    = 1'b0;
        rt_waddr = RUW'(i_in.rule_number);
        rt_wdata = {i_in.rule_length, i_in.rule_head};
        rt_re    = 1'b0;
        rt_raddr = RUW'(dec_target);
        st_we    = 1'b0;
        st_waddr = r_sp[SIW-1:0];
        st_wdata = dec_target;
        st_re    = 1'b0;
        st_raddr = SIW'(sp_popped - SPW'(1));

        // drop the beat once it is taken
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    unique case (t_cmd'(i_in.command))
                        CMD_LOAD_ENTRY: begin
                            at_we = (32'(i_in.table_state) < NUM_STATES) &&
                                    (32'(i_in.table_symbol) < NUM_SYMBOLS);
                            n_state = S_ACK;
                        end
                        CMD_LOAD_RULE: begin
                            rt_we   = 32'(i_in.rule_number) < NUM_RULES;
                            n_state = S_ACK;
                        end
                        CMD_START: begin
                            st_we      = 1'b1;
                            st_waddr   = '0;
                            st_wdata   = '0;
                            n_sp       = SPW'(1);
                            n_top      = '0;
                            n_finished = 1'b0;
                            n_state    = S_ACK;
                        end
                        CMD_TOKEN: begin
                            n_tok     = i_in.token_type;
                            n_reduces = '0;
                            if (r_finished || 32'(i_in.token_type) >= NUM_SYMBOLS) begin
                                n_state = S_ERR;
                            end else begin
                                n_state = S_ACT;
                            end
                        end
                        default: n_state = S_ERR;
                    endcase
                end
            end
            S_ACK: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_res   = EV_ACK;
                    n_out_value = '0;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_ACT: begin
                if (r_sp == '0 || 32'(r_top) >= NUM_STATES) begin
                    n_state = S_ERR;
                end else begin
                    at_re   = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                unique case (dec_kind)
                    KIND_SHIFT: begin
                        if (r_sp >= DEPTH_SP) begin
                            n_state = S_ERR;
                        end else if (slot_free) begin
                            st_we       = 1'b1;
                            n_sp        = r_sp + SPW'(1);
                            n_top       = dec_target;
                            n_out_valid = 1'b1;
                            n_out_res   = EV_SHIFT;
                            n_out_value = dec_target;
                            n_out_last  = 1'b1;
                            n_state     = S_IDLE;
                        end
                    end
                    KIND_ACCEPT: begin
                        if (slot_free) begin
                            n_finished  = 1'b1;
                            n_out_valid = 1'b1;
                            n_out_res   = EV_ACCEPT;
                            n_out_value = '0;
                            n_out_last  = 1'b1;
                            n_state     = S_IDLE;
                        end
                    end
                    KIND_REDUCE: begin
                        if (32'(r_reduces) >= MAX_REDUCES ||
                            32'(dec_target) >= NUM_RULES) begin
                            n_state = S_ERR;
                        end else begin
                            rt_re   = 1'b1;
                            n_rule  = dec_target;
                            n_state = S_RULE;
                        end
                    end
                    default: n_state = S_ERR;
                endcase
            end
            S_RULE: begin
                if (32'(rule_len) >= 32'(r_sp) || 32'(rule_hd) >= NUM_SYMBOLS) begin
                    n_state = S_ERR;
                end else begin
                    n_sp   = sp_popped;
                    n_head = rule_hd;
                    if (rule_len == '0) begin
                        // empty rule: top is unchanged, go straight to goto lookup
                        at_re    = 1'b1;
                        at_raddr = f_at_addr(r_top, rule_hd);
                        n_state  = S_GTD;
                    end else begin
                        st_re   = 1'b1;
                        n_state = S_POP;
                    end
                end
            end
            S_POP: begin
                n_top = r_st_rdata;
                if (32'(r_st_rdata) >= NUM_STATES) begin
                    n_state = S_ERR;
                end else begin
                    at_re    = 1'b1;
                    at_raddr = f_at_addr(r_st_rdata, r_head);
                    n_state  = S_GTD;
                end
            end
            S_GTD: begin
                if (r_sp >= DEPTH_SP) begin
                    n_state = S_ERR;
                end else if (slot_free) begin
                    st_we       = 1'b1;
                    n_sp        = r_sp + SPW'(1);
                    n_top       = dec_target;
                    n_reduces   = r_reduces + RW'(1);
                    n_out_valid = 1'b1;
                    n_out_res   = EV_REDUCE;
                    n_out_value = r_rule;
                    n_out_last  = 1'b0;
                    n_state     = S_ACT;
                end
            end
            S_ERR: begin
                if (slot_free) begin
                    n_finished  = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_res   = EV_ERROR;
                    n_out_value = '0;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sp        <= '0;
            r_finished  <= 1'b1;
            r_reduces   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sp        <= n_sp;
            r_finished  <= n_finished;
            r_reduces   <= n_reduces;
            r_out_valid <= n_out_valid;
        end
        r_top       <= n_top;
        r_tok       <= n_tok;
        r_head      <= n_head;
        r_rule      <= n_rule;
        r_out_res   <= n_out_res;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (at_we) begin
            r_action_mem[at_waddr] <= at_wdata;
        end
        if (at_re) begin
            r_at_rdata <= r_action_mem[at_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rt_we) begin
            r_rule_mem[rt_waddr] <= rt_wdata;
        end
        if (rt_re) begin
            r_rt_rdata <= r_rule_mem[rt_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_stack_mem[st_waddr] <= st_wdata;
        end
        if (st_re) begin
            r_st_rdata <= r_stack_mem[st_raddr];
        end
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.event_res   = r_out_res;
    assign o_out.event_value = r_out_value;
    assign o_out.last        = r_out_last;

    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= DEPTH_SP)
        else $error("stack pointer beyond stack depth");

    a_reduce_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_reduces) <= MAX_REDUCES)
        else $error("reduction count beyond limit");

    a_goto_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GTD) |-> (r_sp != '0))
        else $error("goto push with empty stack");

    a_idle_token_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.command == CMD_TOKEN && r_finished)
        |=> (r_state == S_ERR))
        else $error("token without active parse did not report error");

endmodule

FILE: verif/lrp_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lrp_checker
// Watches both channels of the LR parse engine. Every accepted command beat
// runs through a local copy of the tables, the state stack and the parse
// flag, and the events it should cause are queued. Each accepted event beat
// is compared field by field with the oldest queued event.
// ----------------------------------------------------------------------------
module lrp_checker import lrp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    lrp_in_if    in_ch,
    lrp_out_if   out_ch,
    output int   o_mismatches,
    output int   o_pending
);

    typedef struct packed {
        t_kind               kind;
        logic [TARGET_W-1:0] target;
    } t_action;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [HEAD_W-1:0] head;
    } t_rule;

    typedef struct packed {
        t_event           res;
        logic [VAL_W-1:0] value;
        logic             last;
    } t_event_beat;

    t_action            action_mem [DEF_NUM_STATES*DEF_NUM_SYMBOLS];
    t_rule              rule_mem [DEF_NUM_RULES];
    logic [STATE_W-1:0] state_stack [DEF_STACK_DEPTH];
    int                 stack_depth = 0;
    bit                 parse_idle = 1'b1;
    t_event_beat        expected_events [$];
    int                 mismatches = 0;

    function automatic void queue_event(t_event res, logic [VAL_W-1:0] value, logic last);
        t_event_beat ev;
        ev.res   = res;
        ev.value = value;
        ev.last  = last;
        expected_events = {expected_events, ev};
    endfunction

    function automatic void report(string field, int want, int got);
        $error("%s: expected %0d, actual %0d", field, want, got);
        mismatches++;
    endfunction

    // Reductions first, then one shift, accept or error per token
    task automatic parse_token(input logic [TOKEN_W-1:0] tok);
        t_action act;
        t_rule   rule_word;
        int      top;
        int      reduces;
        bit      running;
        bit      failed;
        reduces = 0;
        running = !parse_idle && (tok < DEF_NUM_SYMBOLS);
        failed  = !running;
        while (running) begin
            running = 1'b0;
            failed  = 1'b1;
            if (stack_depth > 0 && stack_depth <= DEF_STACK_DEPTH) begin
                top = state_stack[stack_depth-1];
                if (top < DEF_NUM_STATES) begin
                    act = action_mem[top*DEF_NUM_SYMBOLS + tok];
                    case (act.kind)
                        KIND_SHIFT: begin
                            if (stack_depth < DEF_STACK_DEPTH) begin
                                state_stack[stack_depth] = act.target;
                                stack_depth++;
                                queue_event(EV_SHIFT, act.target, 1'b1);
                                failed = 1'b0;
                            end
                        end
                        KIND_ACCEPT: begin
                            parse_idle = 1'b1;
                            queue_event(EV_ACCEPT, '0, 1'b1);
                            failed = 1'b0;
                        end
                        KIND_REDUCE: begin
                            if (reduces < DEF_MAX_REDUCES && act.target < DEF_NUM_RULES) begin
                                rule_word = rule_mem[act.target];
                                if (rule_word.len < stack_depth &&
                                    rule_word.head < DEF_NUM_SYMBOLS) begin
                                    // pop the right side, then push the goto state
                                    stack_depth -= rule_word.len;
                                    top = state_stack[stack_depth-1];
                                    if (top < DEF_NUM_STATES && stack_depth < DEF_STACK_DEPTH) begin
                                        state_stack[stack_depth] =
                                            action_mem[top*DEF_NUM_SYMBOLS + rule_word.head].target;
                                        stack_depth++;
                                        queue_event(EV_REDUCE, act.target, 1'b0);
                                        reduces++;
                                        running = 1'b1;
                                        failed  = 1'b0;
                                    end
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
        end
        if (failed) begin
            parse_idle = 1'b1;
            queue_event(EV_ERROR, '0, 1'b1);
        end
    endtask

    always @(posedge i_clk) begin
        t_event_beat want;
        t_action     act;
        t_rule       rule_word;
        if (!i_rst_n) begin
            stack_depth = 0;
            parse_idle  = 1'b1;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_events.size() == 0) begin
                    $error("event beat with nothing pending: res %0d value %0d last %0d",
                           out_ch.event_res, out_ch.event_value, out_ch.last);
                    mismatches++;
                end else begin
                    want = expected_events.pop_front();
                    if (out_ch.event_res !== want.res)
                        report("event_res", want.res, out_ch.event_res);
                    if (out_ch.event_value !== want.value)
                        report("event_value", want.value, out_ch.event_value);
                    if (out_ch.last !== want.last)
                        report("last", want.last, out_ch.last);
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                case (in_ch.command)
                    CMD_LOAD_ENTRY: begin
                        act.kind   = t_kind'(in_ch.entry_kind);
                        act.target = in_ch.entry_target;
                        if (in_ch.table_state < DEF_NUM_STATES &&
                            in_ch.table_symbol < DEF_NUM_SYMBOLS)
                            action_mem[in_ch.table_state*DEF_NUM_SYMBOLS + in_ch.table_symbol]
                                = act;
                        queue_event(EV_ACK, '0, 1'b1);
                    end
                    CMD_LOAD_RULE: begin
                        rule_word.len  = in_ch.rule_length;
                        rule_word.head = in_ch.rule_head;
                        if (in_ch.rule_number < DEF_NUM_RULES)
                            rule_mem[in_ch.rule_number] = rule_word;
                        queue_event(EV_ACK, '0, 1'b1);
                    end
                    CMD_START: begin
                        state_stack[0] = '0;
                        stack_depth    = 1;
                        parse_idle     = 1'b0;
                        queue_event(EV_ACK, '0, 1'b1);
                    end
                    CMD_TOKEN: parse_token(in_ch.token_type);
                    default: ;
                endcase
            end
        end
        o_mismatches <= mismatches;
        o_pending    <= expected_events.size();
    end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the LR parse engine: a directed pass over the corner cases
// (no active parse, reduction limit, stack overflow and underflow, bad rule
// numbers, accept and error entries), then random phases. Each phase loads
// a small closed grammar, so no lookup hits an unloaded entry, and feeds
// parses with random tokens, restarts and stray loads. Both channels stall
// at random outside phases 2 and 3; checking happens in lrp_checker.
// ----------------------------------------------------------------------------
module tb;
    import lrp_pkg::*;

    localparam int RANDOM_ITEMS = 320;
    localparam int DRAIN_CYCLES = 500;

    typedef struct packed {
        t_cmd                command;
        logic [STATE_W-1:0]  table_state;
        logic [SYM_W-1:0]    table_symbol;
        t_kind               entry_kind;
        logic [TARGET_W-1:0] entry_target;
        logic [RULE_W-1:0]   rule_number;
        logic [LEN_W-1:0]    rule_length;
        logic [HEAD_W-1:0]   rule_head;
        logic [TOKEN_W-1:0]  token_type;
    } t_cmd_beat;

    logic i_clk;
    logic i_rst_n;
    int   idle_pct = 16;
    int   items_sent = 0;
    int   fail_count;
    int   pending_count;

    lrp_in_if  cmd_ch ();
    lrp_out_if evt_ch ();

    lr_shift_reduce_parse_engine uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .o_out   (evt_ch)
    );

    lrp_checker u_event_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (cmd_ch),
        .out_ch       (evt_ch),
        .o_mismatches (fail_count),
        .o_pending    (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        evt_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            evt_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    // 10 ms
    initial begin
        #(10_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic t_cmd_beat random_beat(t_cmd cmd);
        t_cmd_beat b;
        b.command      = cmd;
        b.table_state  = STATE_W'($urandom);
        b.table_symbol = SYM_W'($urandom);
        b.entry_kind   = t_kind'($urandom_range(0, 3));
        b.entry_target = TARGET_W'($urandom);
        b.rule_number  = RULE_W'($urandom);
        b.rule_length  = LEN_W'($urandom);
        b.rule_head    = HEAD_W'($urandom);
        b.token_type   = TOKEN_W'($urandom);
        return b;
    endfunction

    task automatic put_beat(input t_cmd_beat b);
        while ($urandom_range(0, 99) < idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid        <= 1'b1;
        cmd_ch.command      <= b.command;
        cmd_ch.table_state  <= b.table_state;
        cmd_ch.table_symbol <= b.table_symbol;
        cmd_ch.entry_kind   <= b.entry_kind;
        cmd_ch.entry_target <= b.entry_target;
        cmd_ch.rule_number  <= b.rule_number;
        cmd_ch.rule_length  <= b.rule_length;
        cmd_ch.rule_head    <= b.rule_head;
        cmd_ch.token_type   <= b.token_type;
        do @(posedge i_clk); while (cmd_ch.ready !== 1'b1);
        items_sent++;
    endtask

    task automatic load_entry(input logic [STATE_W-1:0] st, input logic [SYM_W-1:0] sym,
                              input t_kind kind, input logic [TARGET_W-1:0] tgt);
        t_cmd_beat b;
        b = random_beat(CMD_LOAD_ENTRY);
        b.table_state  = st;
        b.table_symbol = sym;
        b.entry_kind   = kind;
        b.entry_target = tgt;
        put_beat(b);
    endtask

    task automatic load_rule(input logic [RULE_W-1:0] num, input logic [LEN_W-1:0] len,
                             input logic [HEAD_W-1:0] head);
        t_cmd_beat b;
        b = random_beat(CMD_LOAD_RULE);
        b.rule_number = num;
        b.rule_length = len;
        b.rule_head   = head;
        put_beat(b);
    endtask

    task automatic start_parse();
        put_beat(random_beat(CMD_START));
    endtask

    task automatic send_token(input logic [TOKEN_W-1:0] tok);
        t_cmd_beat b;
        b = random_beat(CMD_TOKEN);
        b.token_type = tok;
        put_beat(b);
    endtask

    initial begin
        logic [STATE_W-1:0] st_set [$];
        logic [SYM_W-1:0]   tok_set [$];
        logic [HEAD_W-1:0]  head_set [$];
        logic [RULE_W-1:0]  rule_set [$];
        logic [255:0]       st_used;
        logic [63:0]        sym_used;
        logic [127:0]       rule_used;
        logic [STATE_W-1:0] st;
        logic [SYM_W-1:0]   sym;
        logic [RULE_W-1:0]  rn;
        logic [TARGET_W-1:0] tgt;
        t_kind              kind;
        int                 n_st;
        int                 p;
        int                 phase_no;
        int                 directed_items;

        i_rst_n             <= 1'b0;
        cmd_ch.valid        <= 1'b0;
        cmd_ch.command      <= CMD_LOAD_ENTRY;
        cmd_ch.table_state  <= '0;
        cmd_ch.table_symbol <= '0;
        cmd_ch.entry_kind   <= KIND_ERROR;
        cmd_ch.entry_target <= '0;
        cmd_ch.rule_number  <= '0;
        cmd_ch.rule_length  <= '0;
        cmd_ch.rule_head    <= '0;
        cmd_ch.token_type   <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_token(6'd63);                          // no parse since reset
        load_entry(8'd0, 6'd1, KIND_SHIFT, 8'd0);
        load_entry(8'd0, 6'd2, KIND_REDUCE, 8'd127);
        load_rule(7'd127, 4'd0, 6'd63);
        load_entry(8'd0, 6'd63, KIND_ACCEPT, 8'd0); // goto takes the target whatever the kind
        start_parse();
        send_token(6'd2);                           // empty rule runs into the reduction limit
        send_token(6'd1);                           // parse already over
        start_parse();
        send_token(6'd1);
        send_token(6'd2);                           // stack fills before the limit
        load_entry(8'd0, 6'd3, KIND_REDUCE, 8'd200);
        load_entry(8'd0, 6'd4, KIND_REDUCE, 8'd5);
        load_rule(7'd5, 4'd15, 6'd10);
        start_parse();
        send_token(6'd3);                           // rule number beyond the rule table
        start_parse();
        send_token(6'd4);                           // pops below the bottom
        load_entry(8'd0, 6'd5, KIND_ACCEPT, 8'd255);
        load_entry(8'd0, 6'd0, KIND_SHIFT, 8'd255);
        load_entry(8'd255, 6'd0, KIND_ERROR, 8'd255);
        start_parse();
        send_token(6'd0);
        send_token(6'd0);
        start_parse();
        send_token(6'd5);
        directed_items = items_sent;

        // Each phase: a closed grammar over a few states, tokens, heads and
        // rules, fully loaded before the first token reads it.
        phase_no = 0;
        while (items_sent < directed_items + RANDOM_ITEMS) begin
            idle_pct = (phase_no == 2 || phase_no == 3) ? 0 : 16;
            st_set.delete();
            tok_set.delete();
            head_set.delete();
            rule_set.delete();
            st_used   = '0;
            sym_used  = '0;
            rule_used = '0;
            st_set = {STATE_W'(0)};
            st_used[0] = 1'b1;
            n_st = $urandom_range(2, 5);
            while (st_set.size() < n_st) begin
                st = STATE_W'($urandom);
                if (!st_used[st]) begin
                    st_used[st] = 1'b1;
                    st_set = {st_set, st};
                end
            end
            repeat (3) begin
                do sym = SYM_W'($urandom); while (sym_used[sym]);
                sym_used[sym] = 1'b1;
                tok_set = {tok_set, sym};
            end
            repeat (2) begin
                do sym = SYM_W'($urandom); while (sym_used[sym]);
                sym_used[sym] = 1'b1;
                head_set = {head_set, sym};
            end
            repeat (3) begin
                do rn = RULE_W'($urandom); while (rule_used[rn]);
                rule_used[rn] = 1'b1;
                rule_set = {rule_set, rn};
            end

            foreach (st_set[i]) begin
                foreach (tok_set[j]) begin
                    p   = $urandom_range(0, 99);
                    tgt = TARGET_W'($urandom);
                    if (p < 45) begin
                        kind = KIND_SHIFT;
                        tgt  = st_set[$urandom_range(0, st_set.size() - 1)];
                    end else if (p < 80) begin
                        kind = KIND_REDUCE;
                        if ($urandom_range(0, 19) != 0)
                            tgt = {1'b0, rule_set[$urandom_range(0, 2)]};
                        else
                            tgt = TARGET_W'($urandom_range(DEF_NUM_RULES, 255));
                    end else if (p < 88) begin
                        kind = KIND_ACCEPT;
                    end else begin
                        kind = KIND_ERROR;
                    end
                    load_entry(st_set[i], tok_set[j], kind, tgt);
                end
                foreach (head_set[j])
                    load_entry(st_set[i], head_set[j], t_kind'($urandom_range(0, 3)),
                               st_set[$urandom_range(0, st_set.size() - 1)]);
            end
            foreach (rule_set[k])
                load_rule(rule_set[k],
                          ($urandom_range(0, 9) < 7) ? LEN_W'($urandom_range(0, 2))
                                                     : LEN_W'($urandom),
                          head_set[$urandom_range(0, 1)]);

            start_parse();
            repeat (30) begin
                p = $urandom_range(0, 99);
                if (p < 18) begin
                    start_parse();
                end else if (p < 24) begin
                    // stray load into a column this grammar never reads
                    do sym = SYM_W'($urandom); while (sym_used[sym]);
                    load_entry(STATE_W'($urandom), sym, t_kind'($urandom_range(0, 3)),
                               TARGET_W'($urandom));
                end else if (p < 28) begin
                    do rn = RULE_W'($urandom); while (rule_used[rn]);
                    load_rule(rn, LEN_W'($urandom), HEAD_W'($urandom));
                end else begin
                    send_token(tok_set[$urandom_range(0, 2)]);
                end
            end
            phase_no++;
        end

        cmd_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/lrp_pkg.sv
rtl/core/lrp_if.sv
rtl/core/lr_shift_reduce_parse_engine.sv
verif/lrp_checker.sv
verif/tb.sv
